// ----- design/ebgq_pkg.sv -----
package ebgq_pkg;

  localparam int NUM_SOURCES_DEF = 2;
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [15:0] JITTER_GUARD_RST = 16'd50;
  localparam logic [15:0] DEBOUNCE_RST = 16'd30;
  localparam logic [7:0] TOGGLE_STEPS_RST = 8'd4;

  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_JITTER_GUARD = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE = 2'd2;
  localparam logic [1:0] REG_TOGGLE_STEPS = 2'd3;

  localparam logic [1:0] ROT_NONE = 2'd0;
  localparam logic [1:0] ROT_MOVE = 2'd1;
  localparam logic [1:0] ROT_ADJUST = 2'd2;
  localparam logic [1:0] ROT_JITTER = 2'd3;

  localparam logic [2:0] BTN_NONE = 3'd0;
  localparam logic [2:0] BTN_PRESS = 3'd1;
  localparam logic [2:0] BTN_BACK = 3'd2;
  localparam logic [2:0] BTN_CONFIRM = 3'd3;
  localparam logic [2:0] BTN_SILENT = 3'd4;

  localparam logic [1:0] TRN_NONE = 2'd0;
  localparam logic [1:0] TRN_FORWARD = 2'd1;
  localparam logic [1:0] TRN_BACK = 2'd2;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] jitter_guard_ms;
    logic [15:0] debounce_ms;
    logic [7:0]  toggle_steps;
  } cfg_t;

  typedef struct packed {
    logic               source_id;
    logic               source_present;
    logic               poll_ok;
    logic signed [15:0] rotation_delta;
    logic               button_raw;
    logic [31:0]        time_ms;
    logic               transition_active;
    logic               cooking_level;
  } item_t;

  typedef struct packed {
    logic               source_echo;
    logic [1:0]         rotate_action;
    logic signed [15:0] rotate_amount;
    logic [2:0]         button_action;
    logic [1:0]         start_transition;
    logic               mode_toggled;
    logic               mode_on;
    logic               deny_flag;
  } result_t;

  typedef struct packed {
    logic               pressed;
    logic [31:0]        press_start;
    logic [31:0]        last_edge;
    logic               edge_seen;
    logic               consumed;
    logic               shadow_pressed;
    logic [31:0]        shadow_gen;
    logic signed [31:0] acc;
    logic               gesture_used;
  } entry_t;

  typedef struct packed {
    logic        mode_active;
    logic        back_direction;
    logic [31:0] generation;
  } shared_t;

endpackage

// ----- design/ebgq_in_if.sv -----
interface ebgq_in_if;
  logic               valid;
  logic               ready;
  logic               source_id;
  logic               source_present;
  logic               poll_ok;
  logic signed [15:0] rotation_delta;
  logic               button_raw;
  logic [31:0]        time_ms;
  logic               transition_active;
  logic               cooking_level;

  modport source (
    output valid, source_id, source_present, poll_ok, rotation_delta, button_raw, time_ms,
           transition_active, cooking_level,
    input  ready
  );
  modport sink (
    input  valid, source_id, source_present, poll_ok, rotation_delta, button_raw, time_ms,
           transition_active, cooking_level,
    output ready
  );
endinterface

// ----- design/ebgq_out_if.sv -----
interface ebgq_out_if;
  logic               valid;
  logic               ready;
  logic               source_echo;
  logic [1:0]         rotate_action;
  logic signed [15:0] rotate_amount;
  logic [2:0]         button_action;
  logic [1:0]         start_transition;
  logic               mode_toggled;
  logic               mode_on;
  logic               deny_flag;

  modport source (
    output valid, source_echo, rotate_action, rotate_amount, button_action, start_transition,
           mode_toggled, mode_on, deny_flag,
    input  ready
  );
  modport sink (
    input  valid, source_echo, rotate_action, rotate_amount, button_action, start_transition,
           mode_toggled, mode_on, deny_flag,
    output ready
  );
endinterface

// ----- design/ebgq_ram.sv -----
module ebgq_ram #(
  parameter int Width = 8,
  parameter int Depth = 2,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [Width-1:0]     rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/ebgq_regs.sv -----
module ebgq_regs
  import ebgq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);
  cfg_t cfg_q, cfg_d;
  logic [1:0] reg_sel;

  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_LONG_PRESS:   cfg_d.long_press_ms   = pwdata[15:0];
        REG_JITTER_GUARD: cfg_d.jitter_guard_ms = pwdata[15:0];
        REG_DEBOUNCE:     cfg_d.debounce_ms     = pwdata[15:0];
        REG_TOGGLE_STEPS: cfg_d.toggle_steps    = pwdata[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LONG_PRESS:   prdata = {16'd0, cfg_q.long_press_ms};
      REG_JITTER_GUARD: prdata = {16'd0, cfg_q.jitter_guard_ms};
      REG_DEBOUNCE:     prdata = {16'd0, cfg_q.debounce_ms};
      REG_TOGGLE_STEPS: prdata = {24'd0, cfg_q.toggle_steps};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms   <= LONG_PRESS_RST;
      cfg_q.jitter_guard_ms <= JITTER_GUARD_RST;
      cfg_q.debounce_ms     <= DEBOUNCE_RST;
      cfg_q.toggle_steps    <= TOGGLE_STEPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ----- design/ebgq_core.sv -----
module ebgq_core
  import ebgq_pkg::*;
#(
  parameter int NumSources = NUM_SOURCES_DEF
) (
  input  item_t   item_i,
  input  entry_t  ent_i,
  input  shared_t sh_i,
  input  cfg_t    cfg_i,
  output entry_t  ent_o,
  output shared_t sh_o,
  output logic    wr_o,
  output result_t res_o
);
  logic               src_ok;
  logic               nz;
  logic signed [31:0] delta32;
  logic signed [31:0] acc_sum;
  logic signed [31:0] steps;
  logic [31:0]        since;
  logic [31:0]        held;
  logic               guard;
  logic               bounce;
  logic               was;
  logic               pressed;
  logic               d;

  assign src_ok  = item_i.source_present && (32'(item_i.source_id) < 32'(NumSources));
  assign nz      = (item_i.rotation_delta != 16'sd0);
  assign delta32 = 32'(item_i.rotation_delta);
  assign acc_sum = ent_i.acc + delta32;
  assign steps   = $signed({24'd0, cfg_i.toggle_steps});
  assign since   = item_i.time_ms - ent_i.last_edge;
  assign held    = item_i.time_ms - ent_i.press_start;
  assign guard   = ent_i.edge_seen && (since < {16'd0, cfg_i.jitter_guard_ms});
  assign bounce  = ent_i.edge_seen && (since < {16'd0, cfg_i.debounce_ms});
  assign was     = ent_i.pressed;
  assign pressed = bounce ? was : item_i.button_raw;

  always_comb begin
    ent_o = ent_i;
    sh_o  = sh_i;
    wr_o  = 1'b0;
    d     = 1'b0;
    res_o = '0;
    res_o.source_echo = item_i.source_id;
    if (src_ok) begin
      if (item_i.transition_active) begin
        wr_o = 1'b1;
        if (ent_o.shadow_gen != sh_i.generation) begin
          ent_o.shadow_gen     = sh_i.generation;
          ent_o.shadow_pressed = ent_i.pressed;
        end
        if (item_i.poll_ok) begin
          d = nz;
          if (sh_i.back_direction) begin
            if (item_i.button_raw && !ent_o.shadow_pressed) begin
              d = 1'b1;
            end
            ent_o.shadow_pressed = item_i.button_raw;
          end
          res_o.deny_flag = d;
        end
      end else if (item_i.poll_ok) begin
        wr_o = 1'b1;
        // rotation: held-button gesture, ordinary move, or suppressed
        if (pressed && was && !ent_i.consumed && !ent_i.gesture_used && nz && !guard) begin
          ent_o.acc = acc_sum;
          if (acc_sum >= steps || acc_sum <= -steps) begin
            sh_o.mode_active   = !sh_i.mode_active;
            ent_o.gesture_used = 1'b1;
            ent_o.consumed     = 1'b1;
            res_o.mode_toggled = 1'b1;
          end
        end else if (nz && !guard) begin
          res_o.rotate_action = item_i.cooking_level ? ROT_ADJUST : ROT_MOVE;
          res_o.rotate_amount = item_i.rotation_delta;
        end else if (nz) begin
          res_o.rotate_action = ROT_JITTER;
        end
        // button
        if (pressed && !was) begin
          res_o.button_action = BTN_PRESS;
          ent_o.press_start   = item_i.time_ms;
          ent_o.last_edge     = item_i.time_ms;
          ent_o.edge_seen     = 1'b1;
          ent_o.consumed      = 1'b0;
          ent_o.acc           = '0;
          ent_o.gesture_used  = 1'b0;
        end else if (pressed && was && !ent_o.consumed) begin
          if (held >= {16'd0, cfg_i.long_press_ms}) begin
            res_o.button_action    = BTN_BACK;
            res_o.start_transition = TRN_BACK;
            ent_o.consumed         = 1'b1;
            sh_o.back_direction    = 1'b1;
            sh_o.generation        = sh_i.generation + 32'd1;
          end
        end else if (!pressed && was) begin
          ent_o.last_edge = item_i.time_ms;
          ent_o.edge_seen = 1'b1;
          if (ent_o.consumed) begin
            res_o.button_action = BTN_SILENT;
          end else begin
            res_o.button_action    = BTN_CONFIRM;
            res_o.start_transition = TRN_FORWARD;
            sh_o.back_direction    = 1'b0;
            sh_o.generation        = sh_i.generation + 32'd1;
          end
        end
        ent_o.pressed = pressed;
      end
    end
    res_o.mode_on = sh_o.mode_active;
  end
endmodule

// ----- design/encoder_button_gesture_qualifier_unit.sv -----
// rotary encoder with push button: debounce, long press and held-rotate gesture
// in_i carries one poll word per source (valid/ready); out_o returns exactly
// one result word per poll, in order. configuration goes through the apb port
// (long press, jitter guard, debounce, toggle steps at 0x0, 0x4, 0x8, 0xc); the
// user must write it only while the block is idle (not enforced); pready is
// always high. per-source state lives in one synchronous ram indexed by source
// id; the mode, back direction and transition epoch are kept in flops.
// a poll is registered with its ram read when accepted; it is then evaluated,
// written back and its result loaded into the output register once not stalled.
// throughput: one word per cycle unless stalled; a write-back register forwards
// the entry just written, so consecutive polls of the same source need no bubble.
// reset: all per-source entries read as zero through per-entry valid flops,
// shared state clears and the registers take their default values; the block
// takes words from the first cycle after reset.
// when the receiver stalls the output register holds its word, the stage
// behind it holds one more, and ready drops only once both are full.
module encoder_button_gesture_qualifier_unit
  import ebgq_pkg::*;
#(
  parameter int NumSources = NUM_SOURCES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ebgq_in_if.sink           in_i,
  ebgq_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);
  localparam int AddrW = (NumSources > 1) ? $clog2(NumSources) : 1;
  localparam int EntW  = $bits(entry_t);

  cfg_t    cfg;
  item_t   in_item;
  item_t   p1_q;
  logic    p1_valid_q, p1_valid_d;
  logic    accept, adv;
  logic    addr_ok;
  logic [AddrW-1:0] p1_addr;
  logic [EntW-1:0]  rdata;
  entry_t  ent_cur, ent_new;
  shared_t sh_q, sh_new;
  logic    wr;
  result_t res_new, res_q;
  logic    out_valid_q, out_valid_d;
  logic [NumSources-1:0] vld_q;
  logic    fwd_valid_q;
  logic [AddrW-1:0] fwd_addr_q;
  entry_t  fwd_data_q;

  ebgq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_item.source_id         = in_i.source_id;
  assign in_item.source_present    = in_i.source_present;
  assign in_item.poll_ok           = in_i.poll_ok;
  assign in_item.rotation_delta    = in_i.rotation_delta;
  assign in_item.button_raw        = in_i.button_raw;
  assign in_item.time_ms           = in_i.time_ms;
  assign in_item.transition_active = in_i.transition_active;
  assign in_item.cooking_level     = in_i.cooking_level;

  assign adv        = p1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !p1_valid_q || adv;
  assign accept     = in_i.valid && in_i.ready;

  assign p1_addr = AddrW'(p1_q.source_id);
  assign addr_ok = 32'(p1_q.source_id) < 32'(NumSources);

  ebgq_ram #(
    .Width (EntW),
    .Depth (NumSources)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (adv && wr),
    .waddr_i (p1_addr),
    .wdata_i (ent_new),
    .re_i    (accept),
    .raddr_i (AddrW'(in_i.source_id)),
    .rdata_o (rdata)
  );

  always_comb begin
    ent_cur = '0;
    if (addr_ok) begin
      if (fwd_valid_q && (fwd_addr_q == p1_addr)) begin
        ent_cur = fwd_data_q;
      end else if (vld_q[p1_addr]) begin
        ent_cur = entry_t'(rdata);
      end
    end
  end

  ebgq_core #(
    .NumSources (NumSources)
  ) u_core (
    .item_i (p1_q),
    .ent_i  (ent_cur),
    .sh_i   (sh_q),
    .cfg_i  (cfg),
    .ent_o  (ent_new),
    .sh_o   (sh_new),
    .wr_o   (wr),
    .res_o  (res_new)
  );

  always_comb begin
    p1_valid_d = p1_valid_q;
    if (accept) begin
      p1_valid_d = 1'b1;
    end else if (adv) begin
      p1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sh_q        <= '0;
      vld_q       <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        sh_q <= sh_new;
      end
      if (adv && wr) begin
        vld_q[p1_addr] <= 1'b1;
        fwd_valid_q    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_q <= in_item;
    end
    if (adv) begin
      res_q <= res_new;
    end
    if (adv && wr) begin
      fwd_addr_q <= p1_addr;
      fwd_data_q <= ent_new;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.source_echo      = res_q.source_echo;
  assign out_o.rotate_action    = res_q.rotate_action;
  assign out_o.rotate_amount    = res_q.rotate_amount;
  assign out_o.button_action    = res_q.button_action;
  assign out_o.start_transition = res_q.start_transition;
  assign out_o.mode_toggled     = res_q.mode_toggled;
  assign out_o.mode_on          = res_q.mode_on;
  assign out_o.deny_flag        = res_q.deny_flag;
endmodule

// ----- sim/gesture_scoreboard.sv -----
`timescale 1ns / 1ps
module gesture_scoreboard
  import ebgq_pkg::*;
#(
  parameter int NumSources = NUM_SOURCES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ebgq_in_if                in_w,
  ebgq_out_if               out_w,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                words_pending
);

  cfg_t timing;

  logic        btn_down    [NumSources];
  logic [31:0] hold_since  [NumSources];
  logic [31:0] edge_at     [NumSources];
  logic        edge_valid  [NumSources];
  logic        hold_spent  [NumSources];
  logic        shadow_down [NumSources];
  logic [31:0] shadow_stamp[NumSources];
  int          spin_sum    [NumSources];
  logic        spin_done   [NumSources];
  logic        mode_q;
  logic        back_q;
  logic [31:0] epoch_q;

  result_t predicted_words[$];
  result_t oldest;
  item_t   taken;

  task automatic clear_model();
    timing.long_press_ms   = LONG_PRESS_RST;
    timing.jitter_guard_ms = JITTER_GUARD_RST;
    timing.debounce_ms     = DEBOUNCE_RST;
    timing.toggle_steps    = TOGGLE_STEPS_RST;
    for (int i = 0; i < NumSources; i++) begin
      btn_down[i]     = 1'b0;
      hold_since[i]   = '0;
      edge_at[i]      = '0;
      edge_valid[i]   = 1'b0;
      hold_spent[i]   = 1'b0;
      shadow_down[i]  = 1'b0;
      shadow_stamp[i] = '0;
      spin_sum[i]     = 0;
      spin_done[i]    = 1'b0;
    end
    mode_q  = 1'b0;
    back_q  = 1'b0;
    epoch_q = '0;
    predicted_words.delete();
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("[%0t] mismatch on %s: got %0d, predicted %0d", $time, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // one poll through the debounce, gesture and transition logic
  function automatic result_t qualify_poll(input item_t w);
    result_t     r;
    int          s;
    int          delta;
    int          spin;
    logic [31:0] since;
    logic        guard;
    logic        bounce;
    logic        was;
    logic        down;
    logic        deny;
    r = '0;
    r.source_echo = w.source_id;
    delta = {{16{w.rotation_delta[15]}}, w.rotation_delta};
    s = int'(w.source_id);
    if (w.source_present && s < NumSources) begin
      if (w.transition_active) begin
        if (shadow_stamp[s] != epoch_q) begin
          shadow_stamp[s] = epoch_q;
          shadow_down[s]  = btn_down[s];
        end
        if (w.poll_ok) begin
          deny = (delta != 0);
          if (back_q) begin
            if (w.button_raw && !shadow_down[s]) begin
              deny = 1'b1;
            end
            shadow_down[s] = w.button_raw;
          end
          r.deny_flag = deny;
        end
      end else if (w.poll_ok) begin
        since  = w.time_ms - edge_at[s];
        guard  = edge_valid[s] && (since < 32'(timing.jitter_guard_ms));
        bounce = edge_valid[s] && (since < 32'(timing.debounce_ms));
        was    = btn_down[s];
        down   = bounce ? was : w.button_raw;

        if (down && was && !hold_spent[s] && !spin_done[s] && delta != 0 && !guard) begin
          spin = spin_sum[s] + delta;
          spin_sum[s] = spin;
          if (spin >= int'(timing.toggle_steps) || spin <= -int'(timing.toggle_steps)) begin
            mode_q        = !mode_q;
            spin_done[s]  = 1'b1;
            hold_spent[s] = 1'b1;
            r.mode_toggled = 1'b1;
          end
        end else if (delta != 0 && !guard) begin
          r.rotate_action = w.cooking_level ? ROT_ADJUST : ROT_MOVE;
          r.rotate_amount = w.rotation_delta;
        end else if (delta != 0) begin
          r.rotate_action = ROT_JITTER;
        end

        if (down && !was) begin
          r.button_action = BTN_PRESS;
          hold_since[s]   = w.time_ms;
          edge_at[s]      = w.time_ms;
          edge_valid[s]   = 1'b1;
          hold_spent[s]   = 1'b0;
          spin_sum[s]     = 0;
          spin_done[s]    = 1'b0;
        end else if (down && was && !hold_spent[s]) begin
          if ((w.time_ms - hold_since[s]) >= 32'(timing.long_press_ms)) begin
            r.button_action    = BTN_BACK;
            r.start_transition = TRN_BACK;
            hold_spent[s]      = 1'b1;
            back_q             = 1'b1;
            epoch_q            = epoch_q + 32'd1;
          end
        end else if (!down && was) begin
          edge_at[s]    = w.time_ms;
          edge_valid[s] = 1'b1;
          if (hold_spent[s]) begin
            r.button_action = BTN_SILENT;
          end else begin
            r.button_action    = BTN_CONFIRM;
            r.start_transition = TRN_FORWARD;
            back_q             = 1'b0;
            epoch_q            = epoch_q + 32'd1;
          end
        end
        btn_down[s] = down;
      end
    end
    r.mode_on = mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      fail_count = 0;
    end else begin
      if (out_w.valid && out_w.ready) begin
        if (predicted_words.size() == 0) begin
          report_mismatch("result word with none predicted", 1, 0);
        end else begin
          oldest = predicted_words.pop_front();
          check_field("source_echo", out_w.source_echo, oldest.source_echo);
          check_field("rotate_action", out_w.rotate_action, oldest.rotate_action);
          check_field("rotate_amount", out_w.rotate_amount, oldest.rotate_amount);
          check_field("button_action", out_w.button_action, oldest.button_action);
          check_field("start_transition", out_w.start_transition, oldest.start_transition);
          check_field("mode_toggled", out_w.mode_toggled, oldest.mode_toggled);
          check_field("mode_on", out_w.mode_on, oldest.mode_on);
          check_field("deny_flag", out_w.deny_flag, oldest.deny_flag);
        end
      end
      if (in_w.valid && in_w.ready) begin
        taken = {in_w.source_id, in_w.source_present, in_w.poll_ok, in_w.rotation_delta,
                 in_w.button_raw, in_w.time_ms, in_w.transition_active, in_w.cooking_level};
        predicted_words.push_back(qualify_poll(taken));
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_LONG_PRESS:   timing.long_press_ms   = pwdata[15:0];
          REG_JITTER_GUARD: timing.jitter_guard_ms = pwdata[15:0];
          REG_DEBOUNCE:     timing.debounce_ms     = pwdata[15:0];
          REG_TOGGLE_STEPS: timing.toggle_steps    = pwdata[7:0];
          default: ;
        endcase
      end
    end
    words_pending = predicted_words.size();
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import ebgq_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                words_pending;

  ebgq_in_if  in_w ();
  ebgq_out_if out_w ();

  encoder_button_gesture_qualifier_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_w),
    .out_o   (out_w),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gesture_scoreboard u_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_w          (in_w),
    .out_w         (out_w),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // stimulus-side copies of the timing registers, used to aim the time steps
  int unsigned lp_ms = 500;
  int unsigned jg_ms = 50;
  int unsigned db_ms = 30;
  int unsigned ts_n  = 4;
  logic [31:0] clock_ms;
  int          burst_left;
  int          gap;
  int          anim_left;
  int          items_sent;
  int          stall_left;
  int          stall_kind;
  int          stall_phase;

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(2);
      stall_left = $urandom_range(16, 256);
    end
    stall_left--;
    stall_phase++;
    case (stall_kind)
      0:       out_w.ready = 1'b1;
      1:       out_w.ready = ($urandom_range(3) != 0);
      default: out_w.ready = (stall_phase % 11) < 4;
    endcase
  end

  function automatic item_t mk(input logic sid, input logic present, input logic ok,
                               input int delta, input logic raw, input logic [31:0] t,
                               input logic trans, input logic cook);
    item_t w;
    w.source_id         = sid;
    w.source_present    = present;
    w.poll_ok           = ok;
    w.rotation_delta    = 16'(delta);
    w.button_raw        = raw;
    w.time_ms           = t;
    w.transition_active = trans;
    w.cooking_level     = cook;
    return w;
  endfunction

  function automatic int unsigned step_ms();
    case ($urandom_range(9))
      0:       return 0;
      1:       return jg_ms + $urandom_range(2) - ((jg_ms != 0) ? 1 : 0);
      2:       return db_ms + $urandom_range(2) - ((db_ms != 0) ? 1 : 0);
      3:       return $urandom_range(40, 2000);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int small_delta();
    return int'($urandom_range(6)) - 3;
  endfunction

  task automatic drive(input item_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_w.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    {in_w.source_id, in_w.source_present, in_w.poll_ok, in_w.rotation_delta, in_w.button_raw,
     in_w.time_ms, in_w.transition_active, in_w.cooking_level} = w;
    in_w.valid = 1'b1;
    do @(posedge clk_i); while (!in_w.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic poll(input logic sid, input logic raw, input int delta, input int unsigned dt);
    logic trans;
    clock_ms = clock_ms + dt;
    if (anim_left > 0) begin
      trans = 1'b1;
      anim_left--;
    end else begin
      trans = 1'b0;
      if ($urandom_range(99) < 5) anim_left = $urandom_range(1, 6);
    end
    drive(mk(sid, $urandom_range(99) >= 3, $urandom_range(99) >= 3, delta, raw, clock_ms,
             trans, 1'($urandom_range(1))));
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_timing(input int unsigned lp, input int unsigned jg, input int unsigned db,
                            input int unsigned ts);
    lp_ms = lp;
    jg_ms = jg;
    db_ms = db;
    ts_n  = ts;
    apb_write(REG_LONG_PRESS, lp);
    apb_write(REG_JITTER_GUARD, jg);
    apb_write(REG_DEBOUNCE, db);
    apb_write(REG_TOGGLE_STEPS, ts);
  endtask

  task automatic settle();
    in_w.valid = 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_gestures(input int n);
    int          goal;
    logic        sid;
    int          mag;
    logic [63:0] raw64;
    goal = items_sent + n;
    while (items_sent < goal) begin
      sid = 1'($urandom_range(1));
      case ($urandom_range(9))
        0: begin
          raw64 = {$urandom, $urandom};
          drive(item_t'(raw64[53:0]));
        end
        1, 2: begin
          repeat ($urandom_range(1, 3)) poll(sid, 1'b0, small_delta(), step_ms());
        end
        3, 4: begin
          // short press, sometimes with contact bounce
          poll(sid, 1'b1, small_delta(), step_ms());
          if ($urandom_range(1)) poll(sid, 1'b0, small_delta(), $urandom_range(0, db_ms));
          poll(sid, 1'b1, small_delta(), step_ms());
          poll(sid, 1'b0, small_delta(), step_ms());
          if ($urandom_range(2) == 0) anim_left = $urandom_range(1, 4);
        end
        5, 6: begin
          // hold towards the long-press threshold, which may start a back transition
          poll(sid, 1'b1, 0, step_ms());
          poll(sid, 1'b1, small_delta(), lp_ms / 2 + 1);
          poll(sid, 1'b1, small_delta(), $urandom_range(0, lp_ms / 2 + 2));
          if ($urandom_range(1)) anim_left = $urandom_range(1, 4);
          repeat ($urandom_range(1, 3)) begin
            poll(sid, 1'($urandom_range(1)), small_delta(), step_ms());
          end
          poll(sid, 1'b0, 0, step_ms());
        end
        7, 8: begin
          // rotate while held to toggle the mode
          poll(sid, 1'b1, 0, step_ms());
          poll(sid, 1'b1, 0, jg_ms + 1);
          repeat ($urandom_range(1, 5)) begin
            mag = $urandom_range(1, ts_n / 2 + 1);
            poll(sid, 1'b1, $urandom_range(1) ? mag : -mag, $urandom_range(1, 20));
          end
          poll(sid, 1'b0, small_delta(), step_ms());
        end
        default: begin
          poll(sid, 1'($urandom_range(1)), int'($urandom_range(65535)), step_ms());
        end
      endcase
    end
  endtask

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_w.valid = 1'b0;
    {in_w.source_id, in_w.source_present, in_w.poll_ok, in_w.rotation_delta, in_w.button_raw,
     in_w.time_ms, in_w.transition_active, in_w.cooking_level} = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset timing
    drive(mk(0, 1, 1, 1, 0, 100, 0, 0));
    drive(mk(0, 1, 1, -1, 0, 110, 0, 1));
    drive(mk(1, 1, 1, 32767, 0, 120, 0, 0));
    drive(mk(1, 1, 1, -32768, 0, 130, 0, 1));
    drive(mk(0, 1, 1, 0, 1, 200, 0, 0));
    drive(mk(0, 1, 1, 1, 1, 210, 0, 0));
    drive(mk(0, 1, 1, 0, 0, 215, 0, 0));
    drive(mk(0, 1, 1, 2, 1, 300, 0, 0));
    drive(mk(0, 1, 1, 3, 1, 310, 0, 0));
    drive(mk(0, 1, 1, 1, 1, 320, 0, 0));
    drive(mk(0, 1, 1, 0, 0, 330, 0, 0));
    drive(mk(1, 1, 1, 0, 1, 400, 0, 0));
    drive(mk(1, 1, 1, 0, 1, 950, 0, 0));
    drive(mk(1, 1, 1, -2, 1, 960, 1, 0));
    drive(mk(0, 1, 1, 0, 1, 965, 1, 0));
    drive(mk(1, 1, 0, 5, 1, 970, 1, 0));
    drive(mk(1, 1, 1, 3, 1, 975, 0, 1));
    drive(mk(1, 1, 1, 0, 0, 1000, 0, 0));
    drive(mk(0, 0, 1, 7, 1, 1010, 0, 0));
    drive(mk(0, 1, 0, 7, 1, 1020, 0, 0));
    drive(mk(0, 1, 1, 0, 1, 1100, 0, 0));
    drive(mk(0, 1, 1, 0, 0, 1200, 0, 0));
    drive(mk(1, 1, 1, 0, 1, 32'hFFFF_FFF0, 0, 0));
    drive(mk(1, 1, 1, 0, 0, 32'h0000_0100, 0, 0));
    drive(mk(0, 1, 1, 0, 1, 32'h0000_0200, 1, 0));
    settle();

    set_timing(500, 50, 30, 4);
    clock_ms = $urandom;
    run_gestures(300);
    settle();

    set_timing(0, 0, 0, 1);
    run_gestures(200);
    settle();

    set_timing(0, 0, 0, 0);
    run_gestures(100);
    settle();

    set_timing(65535, 65535, 65535, 255);
    clock_ms = 32'hFFF0_0000;
    run_gestures(250);
    settle();

    set_timing($urandom_range(20, 800), $urandom_range(0, 100), $urandom_range(0, 60),
               $urandom_range(1, 12));
    clock_ms = $urandom;
    run_gestures(350);
    settle();

    set_timing(800, 20, 60, 2);
    clock_ms = 32'hFFFF_F000;
    run_gestures(300);
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
